// ===== hdl/mlbp_pkg.sv =====
// shared types and constants for the eight-port bit-plane frame store
// no dependencies

package mlbp_pkg;

    localparam int MEM_WORDS  = 4096;
    localparam int ADDR_W     = $clog2(MEM_WORDS);
    localparam int CMP_W      = (ADDR_W + 1 > 13) ? ADDR_W + 1 : 13;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] FUNC_PIXEL = 2'd0;
    localparam logic [1:0] FUNC_RAW   = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [2:0] CHIP_RTZ      = 3'd0;
    localparam logic [2:0] CHIP_CLOCKED  = 3'd1;
    localparam logic [2:0] CHIP_RGBW     = 3'd2;
    localparam logic [2:0] CHIP_BRIGHT_A = 3'd3;
    localparam logic [2:0] CHIP_BRIGHT_B = 3'd4;
    localparam logic [2:0] CHIP_FLAG     = 3'd5;

    localparam logic [2:0] ORD_RGB = 3'd0;
    localparam logic [2:0] ORD_RBG = 3'd1;
    localparam logic [2:0] ORD_GRB = 3'd2;
    localparam logic [2:0] ORD_GBR = 3'd3;
    localparam logic [2:0] ORD_BRG = 3'd4;
    localparam logic [2:0] ORD_BGR = 3'd5;

    typedef enum logic [2:0] {
        REG_CHIP_TYPE         = 3'd0,
        REG_RTZ_MODE          = 3'd1,
        REG_COLOUR_ORDER      = 3'd2,
        REG_GLOBAL_BRIGHTNESS = 3'd3,
        REG_PIXEL_COUNT       = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  port;
        logic [9:0]  pixel;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  white;
        logic [11:0] read_address;
    } in_t;

    typedef struct packed {
        logic [63:0] read_word;
        logic        error;
    } out_t;

    typedef struct packed {
        logic [2:0] chip_type;
        logic       rtz_mode;
        logic [2:0] colour_order;
        logic [7:0] global_brightness;
        logic [9:0] pixel_count;
    } cfg_t;

    typedef struct packed {
        logic              accept;
        logic              clr_en;
        logic [ADDR_W-1:0] clr_addr;
        logic              rd_en;
        logic              rd_slot;
        logic [1:0]        rd_step;
        logic              wr_en;
        logic [1:0]        wr_step;
        logic              load_out;
    } cmd_t;

    typedef struct packed {
        logic       do_write;
        logic       do_read;
        logic [1:0] last_step;
    } stat_t;

endpackage

// ===== hdl/mlbp_regs.sv =====
// configuration registers behind the apb-style port
// depends on mlbp_pkg

module mlbp_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mlbp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mlbp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mlbp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output mlbp_pkg::cfg_t                    cfg
);
    import mlbp_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_hit;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_hit = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chip_type         <= CHIP_RTZ;
            cfg_reg.rtz_mode          <= 1'b1;
            cfg_reg.colour_order      <= ORD_GRB;
            cfg_reg.global_brightness <= 8'hFF;
            cfg_reg.pixel_count       <= 10'd170;
        end
        else if (wr_hit)
        begin
            unique case (idx)
                REG_CHIP_TYPE:         cfg_reg.chip_type         <= pwdata[2:0];
                REG_RTZ_MODE:          cfg_reg.rtz_mode          <= pwdata[0];
                REG_COLOUR_ORDER:      cfg_reg.colour_order      <= pwdata[2:0];
                REG_GLOBAL_BRIGHTNESS: cfg_reg.global_brightness <= pwdata[7:0];
                REG_PIXEL_COUNT:       cfg_reg.pixel_count       <= pwdata[9:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_CHIP_TYPE:         prdata[2:0] = cfg_reg.chip_type;
            REG_RTZ_MODE:          prdata[0]   = cfg_reg.rtz_mode;
            REG_COLOUR_ORDER:      prdata[2:0] = cfg_reg.colour_order;
            REG_GLOBAL_BRIGHTNESS: prdata[7:0] = cfg_reg.global_brightness;
            REG_PIXEL_COUNT:       prdata[9:0] = cfg_reg.pixel_count;
            default:               prdata      = '0;
        endcase
    end

endmodule

// ===== hdl/mlbp_datapath.sv =====
// request decode, slot memory with read-modify-write merge, result register
// depends on mlbp_pkg

module mlbp_datapath (
    input  logic           clk,
    input  mlbp_pkg::in_t  in_data,
    input  mlbp_pkg::cfg_t cfg,
    input  mlbp_pkg::cmd_t cmd,
    output mlbp_pkg::stat_t stat,
    output mlbp_pkg::out_t out_data
);
    import mlbp_pkg::*;

    logic [63:0]       mem [MEM_WORDS];
    logic [63:0]       rd_data_reg;
    logic [2:0]        port_reg;
    logic [3:0][7:0]   v_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [1:0]        last_reg;
    logic              is_read_reg;
    logic              err_reg;
    out_t              out_reg;

    logic [3:0][7:0]   v;
    logic [CMP_W-1:0]  base;
    logic [CMP_W-1:0]  last;
    logic [1:0]        n_last;
    logic              dec_err;
    logic              is_write;
    logic              do_write;
    logic              do_read;
    logic [10:0]       raw_limit;
    logic [7:0]        flag;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [63:0]       wr_data;
    logic              wr_any;

    function automatic logic [63:0] put_slot(input logic [63:0] w, input logic [2:0] p,
                                             input logic [7:0] val);
        logic [63:0] r;
        r = w;
        for (int j = 0; j < 8; j++)
        begin
            r[j*8 + int'(p)] = val[7-j];
        end
        return r;
    endfunction

    assign flag      = {2'b11, ~in_data.blue[7:6], ~in_data.green[7:6], ~in_data.red[7:6]};
    assign raw_limit = {1'b0, cfg.pixel_count} + 11'd2;

    always_comb
    begin
        v        = '0;
        base     = '0;
        n_last   = 2'd3;
        dec_err  = 1'b0;
        is_write = 1'b0;
        unique case (in_data.func)
            FUNC_PIXEL:
            begin
                is_write = 1'b1;
                if (cfg.rtz_mode || cfg.chip_type == CHIP_CLOCKED)
                begin
                    n_last = 2'd2;
                    base   = CMP_W'(in_data.pixel) + (CMP_W'(in_data.pixel) << 1);
                    unique case (cfg.colour_order)
                        ORD_RGB:
                        begin
                            v[0] = in_data.red;  v[1] = in_data.green; v[2] = in_data.blue;
                        end
                        ORD_RBG:
                        begin
                            v[0] = in_data.red;  v[1] = in_data.blue;  v[2] = in_data.green;
                        end
                        ORD_GBR:
                        begin
                            v[0] = in_data.green; v[1] = in_data.blue; v[2] = in_data.red;
                        end
                        ORD_BRG:
                        begin
                            v[0] = in_data.blue; v[1] = in_data.red;   v[2] = in_data.green;
                        end
                        ORD_BGR:
                        begin
                            v[0] = in_data.blue; v[1] = in_data.green; v[2] = in_data.red;
                        end
                        default:
                        begin
                            v[0] = in_data.green; v[1] = in_data.red;  v[2] = in_data.blue;
                        end
                    endcase
                end
                else if (cfg.chip_type == CHIP_BRIGHT_A || cfg.chip_type == CHIP_BRIGHT_B)
                begin
                    base = (CMP_W'(in_data.pixel) + CMP_W'(1)) << 2;
                    v[0] = cfg.global_brightness;
                    v[1] = in_data.blue;
                    v[2] = in_data.green;
                    v[3] = in_data.red;
                end
                else if (cfg.chip_type == CHIP_FLAG)
                begin
                    base = (CMP_W'(in_data.pixel) + CMP_W'(1)) << 2;
                    v[0] = flag;
                    v[1] = in_data.red;
                    v[2] = in_data.green;
                    v[3] = in_data.blue;
                end
                else
                begin
                    dec_err = 1'b1;
                end
                if (in_data.pixel >= cfg.pixel_count)
                begin
                    dec_err = 1'b1;
                end
            end
            FUNC_RAW:
            begin
                is_write = 1'b1;
                base     = CMP_W'(in_data.pixel) << 2;
                v[0]     = in_data.green;
                v[1]     = in_data.red;
                v[2]     = in_data.blue;
                v[3]     = in_data.white;
                if (cfg.chip_type < CHIP_RGBW || cfg.chip_type > CHIP_FLAG)
                begin
                    dec_err = 1'b1;
                end
                else if (cfg.chip_type == CHIP_RGBW)
                begin
                    dec_err = in_data.pixel >= cfg.pixel_count;
                end
                else
                begin
                    dec_err = {1'b0, in_data.pixel} >= raw_limit;
                end
            end
            default:
            begin
                is_write = 1'b0;
            end
        endcase
    end

    assign last     = base + CMP_W'(n_last);
    assign do_write = is_write && !dec_err && (last < CMP_W'(MEM_WORDS));
    assign do_read  = (in_data.func == FUNC_READ)
                      && (CMP_W'(in_data.read_address) < CMP_W'(MEM_WORDS));

    assign stat.do_write  = do_write;
    assign stat.do_read   = do_read;
    assign stat.last_step = last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            port_reg    <= in_data.port;
            v_reg       <= v;
            base_reg    <= base[ADDR_W-1:0];
            rd_addr_reg <= ADDR_W'(in_data.read_address);
            last_reg    <= n_last;
            is_read_reg <= do_read;
            err_reg     <= !(do_write || do_read);
        end
    end

    assign rd_addr = cmd.rd_slot ? base_reg + ADDR_W'(cmd.rd_step) : rd_addr_reg;
    assign wr_any  = cmd.clr_en | cmd.wr_en;
    assign wr_addr = cmd.clr_en ? cmd.clr_addr : base_reg + ADDR_W'(cmd.wr_step);
    assign wr_data = cmd.clr_en ? 64'd0 : put_slot(rd_data_reg, port_reg, v_reg[cmd.wr_step]);

    always_ff @(posedge clk)
    begin
        if (wr_any)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.read_word <= is_read_reg ? rd_data_reg : 64'd0;
            out_reg.error     <= err_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== hdl/mlbp_ctrl.sv =====
// sequencer for memory clear, slot read-modify-write and result handoff
// depends on mlbp_pkg

module mlbp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  mlbp_pkg::stat_t stat,
    output mlbp_pkg::cmd_t  cmd
);
    import mlbp_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RMW   = 5'b00100,
        ST_READ  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [2:0]        step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        n_slots;
    logic              accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid & in_ready;
    assign out_valid = out_valid_reg;
    assign n_slots   = {1'b0, stat.last_step} + 3'd1;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        cmd.accept     = accept;
        cmd.clr_addr   = clr_reg;
        cmd.rd_step    = step_reg[1:0];
        cmd.wr_step    = 2'(step_reg - 3'd1);
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (clr_reg == ADDR_W'(MEM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_next = 3'd0;
                    priority if (stat.do_write)
                    begin
                        state_next = ST_RMW;
                    end
                    else if (stat.do_read)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RMW:
            begin
                cmd.rd_slot = 1'b1;
                cmd.rd_en   = (step_reg != n_slots);
                cmd.wr_en   = (step_reg != 3'd0);
                if (step_reg == n_slots)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/multi_port_led_bitplane_packer.sv =====
// top level of the eight-port bit-plane led frame store
// depends on mlbp_pkg, mlbp_regs, mlbp_ctrl, mlbp_datapath
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------
//   in       | in_valid/in_ready  | in_data  (func, port, pixel, colours, address)
//   out      | out_valid/out_ready| out_data (read_word, error)
//   config   | apb psel/penable   | paddr, pwdata, prdata
//
// after reset all 4096 memory words are zeroed one word a cycle; no request is taken
// a pixel or raw write reads and rewrites 3 or 4 slots, a read one word, a rejection none
// the single memory port pair gives one slot read and one slot write per cycle
// the result register lets the next request enter while a result waits on out_ready

module multi_port_led_bitplane_packer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mlbp_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mlbp_pkg::out_t                    out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mlbp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mlbp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mlbp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import mlbp_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    mlbp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mlbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mlbp_datapath u_datapath (
        .clk      (clk),
        .in_data  (in_data),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

    a_no_request_during_clear: assert property (
        @(posedge clk) disable iff (!rst_n) cmd.clr_en |-> !in_ready
    ) else $error("request accepted during memory clear");

    a_single_write_source: assert property (
        @(posedge clk) disable iff (!rst_n) !(cmd.clr_en && cmd.wr_en)
    ) else $error("clear and slot write collide");

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> !in_ready
    ) else $error("second request taken before first finished");

    a_result_from_load: assert property (
        @(posedge clk) disable iff (!rst_n) $rose(out_valid) |-> $past(cmd.load_out)
    ) else $error("result shown without a load");

endmodule
